@@ rtl/assert_macros.svh @@
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/chmt_pkg.sv @@
// Shared types and constants for the cache hit/miss tracker
`default_nettype none

package chmt_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAPPING_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES_IN_USE = 2'd2;
   localparam int CSR_DATA_W = 7;

   // Address width of an access
   localparam int ADDR_W = 32;
   // Width of the running counters
   localparam int COUNT_W = 64;

   // Controller states
   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_HOLD   = 5'b10000
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;    // write one zero line of the clearing pass
      logic start;    // latch a new item
      logic walk;     // issue tag reads and compare returned lines
      logic update;   // fill on a miss, advance the FIFO pointer if fully associative
      logic deliver;  // load the result register and bump the counters
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;  // clearing pass is on its final line
      logic hit_now;   // the line read back matches the block
      logic last_now;  // the line read back is the final one to check
      logic out_free;  // result register can take a new item
   } status_type;

endpackage

`default_nettype wire

@@ rtl/chmt_ram.sv @@
// Generic simple dual-port RAM with registered read
`default_nettype none

module chmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/chmt_ctrl.sv @@
// Controller state machine for the cache hit/miss tracker
`default_nettype none

module chmt_ctrl
   import chmt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // Take an item only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // Sequence clear, lookup, fill and delivery
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.hit_now || status.last_now) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/chmt_datapath.sv @@
// Datapath: configuration, tag store, lookup walk, FIFO pointers and counters
`default_nettype none

module chmt_datapath
   import chmt_pkg::*;
#(
   parameter int MAX_LINES  = 64,
   parameter int LINE_BYTES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  req_access_kind,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [COUNT_W-1:0]         rsp_access_count,
   output logic [COUNT_W-1:0]         rsp_hit_count,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   localparam int IDX_W = $clog2(MAX_LINES);
   localparam int OFF_W = $clog2(LINE_BYTES);
   localparam int TAG_W = ADDR_W - OFF_W;
   localparam int ENT_W = TAG_W + 1;

   // Configuration registers
   logic                  mapping_ff;
   logic                  split_ff;
   logic [CSR_DATA_W-1:0] lines_ff;

   // Item registers
   logic [TAG_W-1:0] block_ff, block_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] lim_ff, lim_in;
   logic             kind_ff, kind_in;

   // Walk registers
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             done_ff, done_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;
   logic             hit_ff, hit_in;

   // FIFO pointers and clearing counter
   logic [IDX_W-1:0] fifo_u_ff, fifo_u_in;
   logic [IDX_W-1:0] fifo_i_ff, fifo_i_in;
   logic [IDX_W-1:0] fifo_d_ff, fifo_d_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   // Result register and counters
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] hits_ff, hits_in;

   // Derived lookup geometry
   logic [IDX_W-1:0] total_mask;
   logic [IDX_W-1:0] cache_mask;
   logic [IDX_W-1:0] cache_base;
   logic [TAG_W-1:0] req_block;

   // Tag store ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [ENT_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENT_W-1:0] ram_rdata;

   // Fill selection
   logic [IDX_W-1:0] fifo_sel;
   logic [IDX_W-1:0] fifo_pos;
   logic [IDX_W-1:0] fifo_next;

   // Capture configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mapping_ff <= 1'b0;
         split_ff   <= 1'b0;
         lines_ff   <= CSR_DATA_W'(64);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAPPING_MODE: mapping_ff <= csr_wdata[0];
            CSR_SPLIT_MODE:   split_ff   <= csr_wdata[0];
            CSR_LINES_IN_USE: lines_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the line count and round it down to a power of two, as a mask
   always_comb begin
      total_mask    = '0;
      total_mask[0] = 1'b1;
      for (int k = 2; k <= IDX_W; k++) begin
         total_mask[k-1] = (32'(lines_ff) >= (32'd1 << k));
      end
   end

   assign cache_mask = split_ff ? (total_mask >> 1) : total_mask;
   assign cache_base = (split_ff && req_access_kind) ? ((total_mask >> 1) + IDX_W'(1)) : '0;
   assign req_block  = req_address[ADDR_W-1:OFF_W];

   // Pick the FIFO pointer of this item's cache
   always_comb begin
      if (!split_ff) begin
         fifo_sel = fifo_u_ff;
      end else if (kind_ff) begin
         fifo_sel = fifo_d_ff;
      end else begin
         fifo_sel = fifo_i_ff;
      end
   end

   assign fifo_pos  = fifo_sel & mask_ff;
   assign fifo_next = (fifo_pos + IDX_W'(1)) & mask_ff;

   // Read the line under walk
   assign ram_raddr = base_ff + start_ff + idx_ff;

   // Compare the line whose read was issued in the previous cycle
   assign status.hit_now  = cmd.walk && pend_ff && ram_rdata[TAG_W]
                            && (ram_rdata[TAG_W-1:0] == block_ff);
   assign status.last_now = cmd.walk && pend_ff && pend_last_ff;
   assign status.clr_last = (clr_ff == IDX_W'(MAX_LINES - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Next-state logic of the datapath
   always_comb begin
      block_in     = block_ff;
      base_in      = base_ff;
      mask_in      = mask_ff;
      start_in     = start_ff;
      lim_in       = lim_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      done_in      = done_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      hit_in       = hit_ff;
      fifo_u_in    = fifo_u_ff;
      fifo_i_in    = fifo_i_ff;
      fifo_d_in    = fifo_d_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      acc_in       = acc_ff;
      hits_in      = hits_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ff;
      ram_wdata    = '0;

      // Sweep the tag store clear after reset
      if (cmd.clear) begin
         ram_we = 1'b1;
         clr_in = clr_ff + IDX_W'(1);
      end

      // Latch the item and set up the walk
      if (cmd.start) begin
         block_in = req_block;
         base_in  = cache_base;
         mask_in  = cache_mask;
         kind_in  = req_access_kind;
         start_in = mapping_ff ? '0 : (req_block[IDX_W-1:0] & cache_mask);
         lim_in   = mapping_ff ? cache_mask : '0;
         idx_in   = '0;
         done_in  = 1'b0;
         pend_in  = 1'b0;
         hit_in   = 1'b0;
      end

      // Issue one read a cycle, compare the one before
      if (cmd.walk) begin
         pend_in = !done_ff;
         if (!done_ff) begin
            pend_last_in = (idx_ff == lim_ff);
            done_in      = (idx_ff == lim_ff);
            idx_in       = idx_ff + IDX_W'(1);
         end
         if (status.hit_now) begin
            hit_in = 1'b1;
         end
      end

      // Fill on a miss and, when fully associative, advance the FIFO pointer
      if (cmd.update && !hit_ff) begin
         ram_we    = 1'b1;
         ram_waddr = mapping_ff ? (base_ff + fifo_pos) : (base_ff + start_ff);
         ram_wdata = {1'b1, block_ff};
         if (mapping_ff) begin
            if (!split_ff) begin
               fifo_u_in = fifo_next;
            end else if (kind_ff) begin
               fifo_d_in = fifo_next;
            end else begin
               fifo_i_in = fifo_next;
            end
         end
      end

      // Drop a taken result, load a new one
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         acc_in       = acc_ff + COUNT_W'(1);
         hits_in      = hits_ff + COUNT_W'(hit_ff);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b1;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         fifo_u_ff    <= '0;
         fifo_i_ff    <= '0;
         fifo_d_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         hits_ff      <= '0;
      end else begin
         done_ff      <= done_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         fifo_u_ff    <= fifo_u_in;
         fifo_i_ff    <= fifo_i_in;
         fifo_d_ff    <= fifo_d_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         hits_ff      <= hits_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      block_ff     <= block_in;
      base_ff      <= base_in;
      mask_ff      <= mask_in;
      start_ff     <= start_in;
      lim_ff       <= lim_in;
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      pend_last_ff <= pend_last_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   // Tag store: valid bit over the full block number
   chmt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_access_count = acc_ff;
   assign rsp_hit_count    = hits_ff;

endmodule

`default_nettype wire

@@ rtl/cache_hit_miss_tracker_unit.sv @@
// Lookup: the tag walk compares one line when direct mapped and, when fully associative,
// lines up to the first hit, at most the cache's lines. One item is handled at a time:
// a new item is taken only after the last one's result is loaded. The tag walk reads
// one line a cycle through the single read port of the tag RAM.
// Reset: synchronous; a clearing pass over all MAX_LINES lines zeroes the valid bits,
// during which no item is taken (configuration writes are taken).
`default_nettype none

module cache_hit_miss_tracker_unit
   import chmt_pkg::*;
#(
   parameter int MAX_LINES  = 64,
   parameter int LINE_BYTES = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [ADDR_W-1:0]     req_address,
   input  wire logic                  req_access_kind,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_hit,
   output logic [COUNT_W-1:0]         rsp_access_count,
   output logic [COUNT_W-1:0]         rsp_hit_count
);

   cmd_type    cmd;
   status_type status;

   // Sequence each item
   chmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the tags, pointers and counters
   chmt_datapath #(
      .MAX_LINES  (MAX_LINES),
      .LINE_BYTES (LINE_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_address      (req_address),
      .req_access_kind  (req_access_kind),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_access_count (rsp_access_count),
      .rsp_hit_count    (rsp_hit_count),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

@@ rtl/chmt_checker.sv @@
// Port checker for the cache hit/miss tracker and its bind
`default_nettype none

`include "assert_macros.svh"

module chmt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_hit,
   input wire logic [63:0] rsp_access_count,
   input wire logic [63:0] rsp_hit_count
);

   // A stalled result holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_access_count) && $stable(rsp_hit_count) && $stable(rsp_hit))

   // One item in flight: an accepted item closes the input
   `CHK_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)

   // Back-to-back results count up by one access
   `CHK_NEXT(a_acc_step, clock, reset, rsp_valid && !rsp_stall, !rsp_valid || (rsp_access_count == $past(rsp_access_count) + 64'd1))

   // Hit count advances only with a hit
   `CHK_NEXT(a_hit_step, clock, reset, rsp_valid && !rsp_stall, !rsp_valid || (rsp_hit_count == $past(rsp_hit_count) + 64'(rsp_hit)))

endmodule

bind cache_hit_miss_tracker_unit chmt_checker u_chmt_checker (.*);

`default_nettype wire

@@ test/cache_hit_miss_tracker_unit_test.sv @@
// Self-checking testbench for the cache hit/miss tracker: tag predictor, scoreboard, stimulus
`timescale 1ns / 1ps

// Which FIFO pointer a fully associative access uses
typedef enum int {
   CACHE_UNIFIED,
   CACHE_INSTR,
   CACHE_DATA
} cache_sel_type;

// One predicted result item
typedef struct packed {
   logic        hit;
   logic [63:0] accesses;
   logic [63:0] hits;
} tally_type;

// Tag store predictor plus the queue of results still owed by the block
class tag_cache_tracker;
   bit          assoc_mode;
   bit          split_mode;
   bit [6:0]    line_request;
   bit          line_valid[64];
   bit [25:0]   line_block[64];
   bit [5:0]    fifo_ptr[3];
   bit [63:0]   access_total;
   bit [63:0]   hit_total;
   tally_type   tally_q[$];
   int          failures;
   int          results_seen;
   int          hits_seen;

   function new();
      line_request = 7'd64;
   endfunction

   function void note_config(logic [chmt_pkg::CSR_IDX_W-1:0] idx,
                             logic [chmt_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         chmt_pkg::CSR_MAPPING_MODE: assoc_mode = data[0];
         chmt_pkg::CSR_SPLIT_MODE:   split_mode = data[0];
         chmt_pkg::CSR_LINES_IN_USE: line_request = data[6:0];
         default: ;
      endcase
   endfunction

   // Clamp to 2..64 and round down to a power of two
   function int cache_lines();
      int v;
      int p;
      v = line_request;
      p = 2;
      if (v > 64) v = 64;
      while ((p << 1) <= v) p = p << 1;
      return p;
   endfunction

   function void note_access(logic [31:0] addr, logic kind);
      int             n;
      int             base;
      int             line;
      int             p;
      cache_sel_type  sel;
      bit [25:0]      blk;
      bit             found;
      tally_type      t;
      n = cache_lines();
      base = 0;
      sel = CACHE_UNIFIED;
      if (split_mode) begin
         n = n / 2;
         base = kind ? n : 0;
         sel = kind ? CACHE_DATA : CACHE_INSTR;
      end
      blk = addr[31:6];
      found = 1'b0;
      if (!assoc_mode) begin
         // Direct mapped: compare the full block number at the indexed line
         line = base + (blk & (n - 1));
         if (line_valid[line] && line_block[line] == blk) begin
            found = 1'b1;
         end else begin
            line_valid[line] = 1'b1;
            line_block[line] = blk;
         end
      end else begin
         // Fully associative: search the whole cache, fill at the FIFO pointer on a miss
         for (int i = 0; i < n; i++) begin
            if (line_valid[base + i] && line_block[base + i] == blk) found = 1'b1;
         end
         if (!found) begin
            p = fifo_ptr[sel] & (n - 1);
            line_valid[base + p] = 1'b1;
            line_block[base + p] = blk;
            fifo_ptr[sel] = 6'((p + 1) & (n - 1));
         end
      end
      access_total++;
      if (found) hit_total++;
      t.hit = found;
      t.accesses = access_total;
      t.hits = hit_total;
      tally_q.push_back(t);
   endfunction

   function void check_result(logic hit, logic [63:0] accesses, logic [63:0] hits);
      tally_type want;
      if (tally_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("result with no access outstanding: hit %0b accesses %0d hits %0d",
                     hit, accesses, hits);
         return;
      end
      want = tally_q.pop_front();
      results_seen++;
      if (want.hit) hits_seen++;
      if (hit !== want.hit || accesses !== want.accesses || hits !== want.hits) begin
         failures++;
         if (failures <= 10)
            $display("mismatch at access %0d: hit %0b/%0b accesses %0d/%0d hits %0d/%0d",
                     want.accesses, want.hit, hit, want.accesses, accesses,
                     want.hits, hits);
      end
   endfunction

   function int pending();
      return tally_q.size();
   endfunction
endclass

module cache_hit_miss_tracker_unit_test;
   import chmt_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS = 160;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  req_access_kind = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_hit;
   logic [COUNT_W-1:0]    rsp_access_count;
   logic [COUNT_W-1:0]    rsp_hit_count;

   tag_cache_tracker tracker = new();

   bit          sender_eager = 1'b0;
   bit          receiver_eager = 1'b0;
   int          settings_run = 0;
   logic [25:0] hot_blocks[80];
   logic [6:0]  phase_lines[RANDOM_PHASES] = '{7'd0, 7'd1, 7'd127, 7'd3, 7'd64,
                                                7'd2, 7'd100, 7'd16, 7'd6, 7'd32};

   cache_hit_miss_tracker_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_address      (req_address),
      .req_access_kind  (req_access_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_access_count (rsp_access_count),
      .rsp_hit_count    (rsp_hit_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle cycles before an item; eager sides never idle
   function automatic int draw_gap(bit eager);
      if (eager) return 0;
      return $urandom_range(0, 12);
   endfunction

   // Mostly blocks from the hot set, some fully random addresses
   function automatic logic [31:0] pick_address(int pool_n);
      logic [25:0] blk;
      if ($urandom_range(0, 99) < 85) blk = hot_blocks[$urandom_range(0, pool_n - 1)];
      else blk = 26'($urandom());
      return {blk, 6'($urandom())};
   endfunction

   // Present one access and hold it until the block takes it
   task automatic send_access(input logic [31:0] addr, input logic kind);
      int gap;
      gap = draw_gap(sender_eager);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_address <= addr;
      req_access_kind <= kind;
      do @(posedge clock); while (req_stall);
      tracker.note_access(addr, kind);
   endtask

   // Drop valid and wait for every owed result
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.note_config(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_setting(input bit assoc, input bit split, input logic [6:0] lines);
      write_reg(CSR_MAPPING_MODE, CSR_DATA_W'(assoc));
      write_reg(CSR_SPLIT_MODE, CSR_DATA_W'(split));
      write_reg(CSR_LINES_IN_USE, lines);
      settings_run++;
   endtask

   // Result side: stall a random while, then take the next item and check it
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_gap(receiver_eager);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_result(rsp_hit, rsp_access_count, rsp_hit_count);
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout with %0d results outstanding", tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int pool_n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Direct mapped, unified, full size: address extremes, offsets, index conflicts
      send_access(32'h0000_0000, 1'b0);
      send_access(32'h0000_003F, 1'b1);
      send_access(32'h0000_0040, 1'b0);
      send_access(32'h0000_1000, 1'b0);
      send_access(32'h0000_0000, 1'b1);
      send_access(32'hFFFF_FFFF, 1'b1);
      send_access(32'hFFFF_FFC0, 1'b0);
      settle();

      // Fully associative split into two-line halves: FIFO wrap in each half
      apply_setting(1'b1, 1'b1, 7'd4);
      send_access(32'h0000_0080, 1'b0);
      send_access(32'h0000_00C0, 1'b0);
      send_access(32'h0000_0100, 1'b0);
      send_access(32'h0000_0080, 1'b0);
      send_access(32'h0000_0080, 1'b1);
      send_access(32'h0000_00C0, 1'b1);
      send_access(32'h0000_0080, 1'b1);
      send_access(32'h0000_0100, 1'b1);
      send_access(32'hFFFF_FFFF, 1'b1);
      settle();

      // Direct mapped split at the smallest size, then stale lines reused
      apply_setting(1'b0, 1'b1, 7'd2);
      send_access(32'h0000_0000, 1'b0);
      send_access(32'h0000_0040, 1'b1);
      send_access(32'h0000_0080, 1'b1);
      send_access(32'hAAAA_AAAA, 1'b0);
      send_access(32'h5555_5555, 1'b1);
      settle();

      // Random phases across every mode and the line counts in phase_lines, odd values included
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         apply_setting(ph[0], ph[1], phase_lines[ph]);
         sender_eager = (ph % 3 == 2);
         receiver_eager = (ph % 4 == 1);
         pool_n = $urandom_range(2, 80);
         for (int b = 0; b < pool_n; b++) hot_blocks[b] = 26'($urandom());
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 4 && k == PHASE_ITEMS / 2) settle();
            send_access(pick_address(pool_n), 1'($urandom()));
         end
         settle();
      end

      // Let any stray result show up before the verdict
      sender_eager = 1'b0;
      receiver_eager = 1'b1;
      repeat (200) @(posedge clock);

      $display("Checked %0d accesses (%0d hits) over %0d register settings,",
               tracker.results_seen, tracker.hits_seen, settings_run);
      $display("direct mapped and fully associative, unified and split, line counts 0 to 127");
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures, %0d results outstanding", tracker.failures,
                  tracker.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
